### src/lz11_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lz11_pkg;

   // history window size in bytes and its address width
   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

endpackage

`default_nettype wire

### src/lz11_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// LZ11 stream decoder. Each req beat carries either one compressed byte (mode 0)
// or a tick (mode 1) that pulls the next byte of a pending back-reference; every
// beat yields exactly one rsp beat via its input and result stages; a new beat
// is taken every cycle while rsp_tready stays high, so literals and copied bytes
// flow at one byte per clock. The rate is set by the single-port read of the
// history RAM, issued as a beat is accepted and forwarded from the byte written
// in that same cycle when a copy distance of one chases its own output. The
// history needs no clearing pass: a fill pointer and a wrap flag make entries
// not written since the last start read as zero. start_req on the first header
// byte restarts parsing; after the declared size the last byte is flagged and
// further bytes are ignored until the next start.
module lz11_stream_decoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] data_byte
   input  wire logic [1:0]  req_tuser,  // [0] mode, [1] start_req
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,  // [7:0] out_byte, [8] copy_pending, [10:9] status
   output logic             rsp_tuser,  // [0] out_valid
   output logic             rsp_tlast   // last
);

   localparam int AW = lz11_pkg::WIN_AW;

   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_FLAG, PH_ITEM, PH_TOKEN, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK, ST_BUSY, ST_NO_COPY
   } status_type;

   typedef enum logic [1:0] {
      TK_MID, TK_LONG, TK_SHORT
   } kind_type;

   // input stage
   logic        s1_valid_ff;
   logic        s1_mode_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_start_ff;
   logic        rd_fill_ok_ff;
   logic        rd_bypass_ff;
   logic [7:0]  rd_bypass_data_ff;

   // result stage
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_out_valid_ff;
   logic        rsp_last_ff;
   logic        rsp_pend_ff;
   status_type  rsp_status_ff;

   // decoder state
   phase_type   phase_ff, phase_in, cur_phase;
   logic [AW-1:0] wp_ff, wp_in, cur_wp;
   logic        wrap_ff, wrap_in, cur_wrap;
   logic [23:0] decl_ff, decl_in, cur_decl;
   logic [23:0] prod_ff, prod_in, cur_prod;
   logic [7:0]  fbits_ff, fbits_in, cur_fbits;
   logic [3:0]  fleft_ff, fleft_in, cur_fleft;
   logic [23:0] tbytes_ff, tbytes_in, cur_tbytes;
   logic [16:0] crem_ff, crem_in, cur_crem;
   logic [11:0] dist_ff, dist_in, cur_dist;
   logic [1:0]  tneed_ff, tneed_in, cur_tneed, tneed_dec;
   kind_type    tkind_ff, tkind_in, cur_tkind;

   logic        advance;
   logic        req_accept;
   logic [7:0]  ram_q;
   logic [7:0]  hist_byte;
   logic [AW-1:0] rd_addr;
   logic        we;
   logic [7:0]  wdata;
   logic        do_emit;
   logic [7:0]  emit_byte;
   logic [23:0] prod_inc;
   logic [16:0] len_long, len_mid, len_short;

   logic [7:0]  o_byte;
   logic        o_valid;
   logic        o_last;
   status_type  o_status;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign hist_byte = rd_bypass_ff  ? rd_bypass_data_ff :
                      rd_fill_ok_ff ? ram_q : 8'd0;

   assign len_long  = 17'({s1_byte_ff[3:0] & 4'h0, tbytes_ff[19:16], 12'd0}) + 17'h100
                    + 17'({tbytes_ff[15:8], 4'd0}) + 17'(tbytes_ff[7:4]) + 17'd17;
   assign len_mid   = 17'({tbytes_ff[15:8], 4'd0}) + 17'(tbytes_ff[7:4]) + 17'd17;
   assign len_short = 17'(tbytes_ff[7:4]) + 17'd1;

   always_comb begin
      // a start request clears everything before the beat is parsed
      cur_phase  = s1_start_ff ? PH_HDR0 : phase_ff;
      cur_wp     = s1_start_ff ? '0 : wp_ff;
      cur_wrap   = s1_start_ff ? 1'b0 : wrap_ff;
      cur_decl   = s1_start_ff ? 24'd0 : decl_ff;
      cur_prod   = s1_start_ff ? 24'd0 : prod_ff;
      cur_fbits  = s1_start_ff ? 8'd0 : fbits_ff;
      cur_fleft  = s1_start_ff ? 4'd0 : fleft_ff;
      cur_tbytes = s1_start_ff ? 24'd0 : tbytes_ff;
      cur_crem   = s1_start_ff ? 17'd0 : crem_ff;
      cur_dist   = s1_start_ff ? 12'd0 : dist_ff;
      cur_tneed  = s1_start_ff ? 2'd0 : tneed_ff;
      cur_tkind  = s1_start_ff ? TK_MID : tkind_ff;
      tneed_dec  = (cur_tneed != 2'd0) ? cur_tneed - 2'd1 : 2'd0;
      prod_inc   = cur_prod + 24'd1;

      phase_in  = phase_ff;
      wp_in     = wp_ff;
      wrap_in   = wrap_ff;
      decl_in   = decl_ff;
      prod_in   = prod_ff;
      fbits_in  = fbits_ff;
      fleft_in  = fleft_ff;
      tbytes_in = tbytes_ff;
      crem_in   = crem_ff;
      dist_in   = dist_ff;
      tneed_in  = tneed_ff;
      tkind_in  = tkind_ff;

      do_emit   = 1'b0;
      emit_byte = s1_byte_ff;
      o_status  = ST_OK;
      o_last    = 1'b0;

      if (advance) begin
         phase_in  = cur_phase;
         wp_in     = cur_wp;
         wrap_in   = cur_wrap;
         decl_in   = cur_decl;
         prod_in   = cur_prod;
         fbits_in  = cur_fbits;
         fleft_in  = cur_fleft;
         tbytes_in = cur_tbytes;
         crem_in   = cur_crem;
         dist_in   = cur_dist;
         tneed_in  = cur_tneed;
         tkind_in  = cur_tkind;

         if (s1_start_ff && s1_mode_ff) begin
            // start tick: clear only
         end else if (s1_mode_ff) begin
            if (cur_crem == 17'd0) begin
               o_status = ST_NO_COPY;
            end else begin
               crem_in   = cur_crem - 17'd1;
               do_emit   = 1'b1;
               emit_byte = hist_byte;
            end
         end else if (cur_crem != 17'd0) begin
            // drop the byte, a copy is still running
            o_status = ST_BUSY;
         end else begin
            unique case (cur_phase)
               PH_HDR0: phase_in = PH_HDR1;
               PH_HDR1: begin
                  decl_in  = {16'd0, s1_byte_ff};
                  phase_in = PH_HDR2;
               end
               PH_HDR2: begin
                  decl_in  = {8'd0, s1_byte_ff, cur_decl[7:0]};
                  phase_in = PH_HDR3;
               end
               PH_HDR3: begin
                  decl_in  = {s1_byte_ff, cur_decl[15:0]};
                  phase_in = ({s1_byte_ff, cur_decl[15:0]} == 24'd0) ? PH_DONE : PH_FLAG;
               end
               PH_FLAG: begin
                  fbits_in = s1_byte_ff;
                  fleft_in = 4'd8;
                  phase_in = PH_ITEM;
               end
               PH_ITEM: begin
                  fbits_in = {cur_fbits[6:0], 1'b0};
                  fleft_in = (cur_fleft != 4'd0) ? cur_fleft - 4'd1 : 4'd0;
                  if (!cur_fbits[7]) begin
                     phase_in = (fleft_in != 4'd0) ? PH_ITEM : PH_FLAG;
                     do_emit  = 1'b1;
                  end else begin
                     case (s1_byte_ff[7:4])
                        4'd0: begin
                           tkind_in = TK_MID;
                           tneed_in = 2'd2;
                        end
                        4'd1: begin
                           tkind_in = TK_LONG;
                           tneed_in = 2'd3;
                        end
                        default: begin
                           tkind_in = TK_SHORT;
                           tneed_in = 2'd1;
                        end
                     endcase
                     tbytes_in = {16'd0, s1_byte_ff};
                     phase_in  = PH_TOKEN;
                  end
               end
               PH_TOKEN: begin
                  tneed_in = tneed_dec;
                  if (tneed_dec == 2'd0) begin
                     case (cur_tkind)
                        TK_LONG: crem_in = len_long;
                        TK_MID:  crem_in = len_mid;
                        default: crem_in = len_short;
                     endcase
                     dist_in  = {cur_tbytes[3:0], s1_byte_ff};
                     phase_in = (cur_fleft != 4'd0) ? PH_ITEM : PH_FLAG;
                  end else begin
                     tbytes_in = {cur_tbytes[15:0], s1_byte_ff};
                  end
               end
               PH_DONE: begin
                  // finished stream: ignore until the next start
               end
            endcase
         end

         if (do_emit) begin
            wp_in   = cur_wp + AW'(1);
            wrap_in = cur_wrap || (cur_wp == {AW{1'b1}});
            prod_in = prod_inc;
            if (prod_inc == cur_decl) begin
               o_last   = 1'b1;
               phase_in = PH_DONE;
               crem_in  = 17'd0;
            end
         end
      end

      we      = do_emit;
      wdata   = emit_byte;
      o_valid = do_emit;
      o_byte  = do_emit ? emit_byte : 8'd0;
   end

   // read for the incoming beat uses the state as it stands after this cycle
   assign rd_addr = wp_in - AW'(1) - AW'(dist_in);

   lz11_ram #(
      .WIDTH (8),
      .DEPTH (lz11_pkg::WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (cur_wp),
      .wr_data (wdata),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HDR0;
         wp_ff        <= '0;
         wrap_ff      <= 1'b0;
         decl_ff      <= 24'd0;
         prod_ff      <= 24'd0;
         fbits_ff     <= 8'd0;
         fleft_ff     <= 4'd0;
         tbytes_ff    <= 24'd0;
         crem_ff      <= 17'd0;
         dist_ff      <= 12'd0;
         tneed_ff     <= 2'd0;
         tkind_ff     <= TK_MID;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         phase_ff  <= phase_in;
         wp_ff     <= wp_in;
         wrap_ff   <= wrap_in;
         decl_ff   <= decl_in;
         prod_ff   <= prod_in;
         fbits_ff  <= fbits_in;
         fleft_ff  <= fleft_in;
         tbytes_ff <= tbytes_in;
         crem_ff   <= crem_in;
         dist_ff   <= dist_in;
         tneed_ff  <= tneed_in;
         tkind_ff  <= tkind_in;
      end

      if (req_accept) begin
         s1_mode_ff        <= req_tuser[0];
         s1_start_ff       <= req_tuser[1];
         s1_byte_ff        <= req_tdata;
         rd_fill_ok_ff     <= wrap_in || (rd_addr < wp_in);
         // forward the byte written in this cycle when it is the one being read
         rd_bypass_ff      <= we && (rd_addr == cur_wp);
         rd_bypass_data_ff <= wdata;
      end

      if (advance) begin
         rsp_byte_ff      <= o_byte;
         rsp_out_valid_ff <= o_valid;
         rsp_last_ff      <= o_last;
         rsp_pend_ff      <= (crem_in != 17'd0);
         rsp_status_ff    <= o_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_pend_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_out_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### src/lz11_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lz11_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read returns the old contents on a same-address write
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
